>>> src/sorted_key_table_unit_macros.svh
// ----------------------------------------------------------------------------
// sorted_key_table_unit_macros.svh
// Assertion macros shared by the sorted key table RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_UNIT_MACROS_SVH
`define SORTED_KEY_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define SKTU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("sorted key table: same-cycle check failed");

// Next-cycle implication, disabled while reset is applied.
`define SKTU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("sorted key table: next-cycle check failed");

`endif

>>> src/sktu_pkg.sv
// ----------------------------------------------------------------------------
// sktu_pkg
// Types and sizing constants shared by the sorted key table cells and top.
// ----------------------------------------------------------------------------
package sktu_pkg;

	localparam int CAPACITY  = 64;
	localparam int KEY_BITS  = 64;
	localparam int DATA_BITS = 32;
	localparam int CNT_W     = $clog2(CAPACITY + 1);

	typedef logic [KEY_BITS-1:0]  key_t;
	typedef logic [DATA_BITS-1:0] data_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	typedef enum logic [1:0] {
		REQ_UPSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_LOOKUP = 2'd2,
		REQ_READ   = 2'd3
	} req_e;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2,
		ST_RANGE    = 2'd3
	} status_e;

	typedef enum logic [1:0] {
		OP_NONE   = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_WRITE  = 2'd3
	} cell_op_e;

	typedef struct packed {
		key_t  key;
		data_t data;
	} entry_t;

	// Broadcast to every cell of the row.
	typedef struct packed {
		logic     cmp;     // compare against key this cycle
		logic     by_pos;  // request selects by position, not by key
		cell_op_e op;      // row update at the end of this cycle
		key_t     key;
		data_t    data;
	} cell_cmd_t;

endpackage

>>> src/sktu_cell.sv
// ----------------------------------------------------------------------------
// sktu_cell
// One entry of the sorted row: compare flags, shift from either neighbor.
// ----------------------------------------------------------------------------
module sktu_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  sktu_pkg::cell_cmd_t cmd,
	input  logic               in_use,   // entry lies below the fill count
	input  logic               pos_sel,  // entry sits at the requested position
	input  sktu_pkg::entry_t   lft,      // entry of the lower neighbor
	input  logic               lft_lt,   // lower neighbor holds a smaller key
	input  sktu_pkg::entry_t   rgt,      // entry of the upper neighbor
	output sktu_pkg::entry_t   ent,
	output logic               lt,
	output logic               pick,
	output sktu_pkg::entry_t   rd
);
	import sktu_pkg::*;

	entry_t ent_q;
	logic   lt_q;
	logic   pick_q;

	// Compare flags, taken in the compare cycle and held through execute.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q   <= 1'b0;
			pick_q <= 1'b0;
		end else if (cmd.cmp) begin
			lt_q <= in_use && (ent_q.key < cmd.key);
			if (cmd.by_pos) begin
				pick_q <= in_use && pos_sel;
			end else begin
				pick_q <= in_use && (ent_q.key == cmd.key);
			end
		end
	end

	// Payload: hold below the insertion point, shift or load above it; a write rewrites the data of the picked entry.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_INSERT: begin
				if (!lt_q) begin
					if (lft_lt) begin
						ent_q.key  <= cmd.key;
						ent_q.data <= cmd.data;
					end else begin
						ent_q <= lft;
					end
				end
			end
			OP_REMOVE: begin
				if (!lt_q) begin
					ent_q <= rgt;
				end
			end
			OP_WRITE: begin
				if (pick_q) begin
					ent_q.data <= cmd.data;
				end
			end
			OP_NONE: begin
			end
			default: begin
			end
		endcase
	end

	assign ent  = ent_q;
	assign lt   = lt_q;
	assign pick = pick_q;
	assign rd   = pick_q ? ent_q : '0;

endmodule

>>> src/sorted_key_table_unit.sv
// ----------------------------------------------------------------------------
// sorted_key_table_unit
// Sorted key/data table held in a row of shifting cells.
// ----------------------------------------------------------------------------
// The table keeps up to CAPACITY entries in ascending key order, one entry per
// cell. An item is taken at a clock edge where start is high and busy is low.
// Each item passes through a compare step, in which every cell checks its key
// against the request key at once, and an execute step, in which the row
// shifts up (insert), shifts down (remove), rewrites one data word or holds
// still, and the result is registered. The result appears on the output ports,
// marked by done, for exactly one cycle: it is driven from the result registers
// written at the end of execute. The receiver cannot hold it off, so take it
// that cycle. busy is high only during the compare cycle, so a new item may be
// accepted during execute, before the row is through with the last one. The
// store contents are undefined after reset: only entries below the fill count
// are ever read, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "sorted_key_table_unit_macros.svh"

module sorted_key_table_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [63:0] key,
	input  logic [31:0] entry_data,
	input  logic [5:0]  position,
	output logic        done,
	output logic        found,
	output logic [6:0]  slot,
	output logic [63:0] key_out,
	output logic [31:0] data_out,
	output logic [6:0]  entry_count,
	output logic [1:0]  status
);
	import sktu_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_EXE
	} state_e;

	state_e state_q;

	// Request held from accept through execute.
	req_e       req_q;
	key_t       key_q;
	data_t      data_q;
	logic [5:0] pos_q;

	cnt_t count_q;

	// Cell row wiring.
	entry_t ent     [CAPACITY];
	entry_t rd      [CAPACITY];
	logic   lt      [CAPACITY];
	logic   pick    [CAPACITY];
	logic   in_use  [CAPACITY];
	logic   pos_sel [CAPACITY];

	cell_cmd_t cmd;

	logic accept;
	logic hit;
	logic full;
	cnt_t ins_pt;
	cnt_t count_nxt;
	key_t rd_key;
	data_t rd_data;
	cell_op_e op;
	status_e  st_nxt;
	logic [31:0] dout_nxt;

	assign accept = start && (state_q != S_CMP);
	assign busy   = (state_q == S_CMP);

	// Fill-count decode and position select, one per cell.
	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_row
			entry_t lft_w;
			entry_t rgt_w;
			logic   lft_lt_w;

			assign in_use[gi]  = (32'(count_q) > 32'(gi));
			assign pos_sel[gi] = (32'(pos_q) == 32'(gi));

			if (gi == 0) begin : g_first
				// Below the first cell everything counts as smaller.
				assign lft_w    = '0;
				assign lft_lt_w = 1'b1;
			end else begin : g_mid
				assign lft_w    = ent[gi-1];
				assign lft_lt_w = lt[gi-1];
			end

			if (gi == CAPACITY - 1) begin : g_last
				assign rgt_w = '0;
			end else begin : g_up
				assign rgt_w = ent[gi+1];
			end

			sktu_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.cmd     (cmd),
				.in_use  (in_use[gi]),
				.pos_sel (pos_sel[gi]),
				.lft     (lft_w),
				.lft_lt  (lft_lt_w),
				.rgt     (rgt_w),
				.ent     (ent[gi]),
				.lt      (lt[gi]),
				.pick    (pick[gi]),
				.rd      (rd[gi])
			);
		end
	endgenerate

	// Gather the picked entry and the insertion point from the row flags.
	// The smaller-key flags form a run from cell zero, so exactly one cell
	// sits at the edge of that run unless every cell is smaller.
	always_comb begin
		hit     = 1'b0;
		rd_key  = '0;
		rd_data = '0;
		ins_pt  = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit     = hit | pick[i];
			rd_key  = rd_key | rd[i].key;
			rd_data = rd_data | rd[i].data;
			if (!lt[i] && ((i == 0) || lt[(i == 0) ? 0 : i - 1])) begin
				ins_pt = ins_pt | CNT_W'(i);
			end
		end
		if (lt[CAPACITY-1]) begin
			ins_pt = CNT_W'(CAPACITY);
		end
	end

	assign full = (count_q == CNT_W'(CAPACITY));

	// Decide the row update and the result of the item in execute.
	always_comb begin
		op        = OP_NONE;
		st_nxt    = ST_OK;
		dout_nxt  = '0;
		count_nxt = count_q;
		unique case (req_q)
			REQ_UPSERT: begin
				if (hit) begin
					op       = OP_WRITE;
					dout_nxt = 32'(data_q);
				end else if (full) begin
					st_nxt = ST_FULL;
				end else begin
					op        = OP_INSERT;
					dout_nxt  = 32'(data_q);
					count_nxt = count_q + CNT_W'(1);
				end
			end
			REQ_REMOVE: begin
				if (hit) begin
					op        = OP_REMOVE;
					dout_nxt  = 32'(rd_data);
					count_nxt = count_q - CNT_W'(1);
				end else begin
					st_nxt = ST_NOTFOUND;
				end
			end
			REQ_LOOKUP: begin
				if (hit) begin
					dout_nxt = 32'(rd_data);
				end else begin
					st_nxt = ST_NOTFOUND;
				end
			end
			REQ_READ: begin
				if (hit) begin
					dout_nxt = 32'(rd_data);
				end else begin
					st_nxt = ST_RANGE;
				end
			end
			default: begin
			end
		endcase
		if (state_q != S_EXE) begin
			op = OP_NONE;
		end
	end

	assign cmd.cmp    = (state_q == S_CMP);
	assign cmd.by_pos = (req_q == REQ_READ);
	assign cmd.op     = op;
	assign cmd.key    = key_q;
	assign cmd.data   = data_q;

	// Sequencer, request capture, fill count and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			done        <= 1'b0;
			req_q       <= REQ_UPSERT;
			key_q       <= '0;
			data_q      <= '0;
			pos_q       <= '0;
			found       <= 1'b0;
			slot        <= '0;
			key_out     <= '0;
			data_out    <= '0;
			entry_count <= '0;
			status      <= ST_OK;
		end else begin
			done <= 1'b0;
			if (accept) begin
				req_q  <= req_e'(req_type);
				key_q  <= key[KEY_BITS-1:0];
				data_q <= DATA_BITS'(entry_data);
				pos_q  <= position;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_EXE;
				end
				S_EXE: begin
					state_q     <= accept ? S_CMP : S_IDLE;
					count_q     <= count_nxt;
					done        <= 1'b1;
					found       <= hit;
					slot        <= (req_q == REQ_READ) ? 7'(pos_q) : 7'(ins_pt);
					key_out     <= (req_q == REQ_READ) ? 64'(rd_key) : 64'(key_q);
					data_out    <= dout_nxt;
					entry_count <= 7'(count_nxt);
					status      <= st_nxt;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Checks on the sequencer and the fill count.
	`SKTU_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy)
	`SKTU_ASSERT_NEXT(a_busy_one_cycle, clk, arst_n, busy, !busy)
	`SKTU_ASSERT_NEXT(a_exe_done, clk, arst_n, state_q == S_EXE, done)
	`SKTU_ASSERT_NOW(a_full_status, clk, arst_n, done && (status == ST_FULL), (!found) && (entry_count == 7'(CAPACITY)))

endmodule
